// ===== design/i2cms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package i2cms_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // command codes carried in func
  localparam logic [FuncW-1:0] CMD_NONE    = 3'd0;
  localparam logic [FuncW-1:0] CMD_START   = 3'd1;
  localparam logic [FuncW-1:0] CMD_STOP    = 3'd2;
  localparam logic [FuncW-1:0] CMD_WRITE   = 3'd3;
  localparam logic [FuncW-1:0] CMD_READACK = 3'd4;
  localparam logic [FuncW-1:0] CMD_READNAK = 3'd5;
  localparam logic [FuncW-1:0] CMD_PROBE   = 3'd6;

  // register indexes
  localparam logic [0:0] REG_TICKS_PER_DELAY = 1'b0;

  localparam logic [DelayW-1:0] TicksPerDelayRst = 16'd1;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] data_byte;
    logic             sda_in;
  } in_word_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic             done_res;
    logic             ack_ok;
    logic [ByteW-1:0] read_byte;
  } out_word_t;

endpackage
`default_nettype wire

// ===== design/i2cms_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cms_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel_i,
  input  wire logic                              penable_i,
  input  wire logic                              pwrite_i,
  input  wire logic [i2cms_pkg::ApbAddrW-1:0]    paddr_i,
  input  wire logic [i2cms_pkg::ApbDataW-1:0]    pwdata_i,
  output logic      [i2cms_pkg::ApbDataW-1:0]    prdata_o,
  output logic                                   pready_o,
  output logic      [i2cms_pkg::DelayW-1:0]      ticks_per_delay_o
);

  logic [i2cms_pkg::DelayW-1:0] tpd_q, tpd_d;
  logic                         reg_sel;
  logic                         wr_en;

  // register index is the word address
  assign reg_sel = (paddr_i[i2cms_pkg::ApbAddrW-1] == i2cms_pkg::REG_TICKS_PER_DELAY);
  assign wr_en   = psel_i & penable_i & pwrite_i & pready_o;

  always_comb begin
    tpd_d = tpd_q;
    if (wr_en && reg_sel) begin
      tpd_d = pwdata_i[i2cms_pkg::DelayW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpd_q <= i2cms_pkg::TicksPerDelayRst;
    end else begin
      tpd_q <= tpd_d;
    end
  end

  assign pready_o          = 1'b1;
  assign prdata_o          = reg_sel ? {{(i2cms_pkg::ApbDataW - i2cms_pkg::DelayW){1'b0}}, tpd_q}
                                     : '0;
  assign ticks_per_delay_o = tpd_q;

endmodule
`default_nettype wire

// ===== design/i2cms_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cms_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire i2cms_pkg::in_word_t           word_i,
  input  wire logic [i2cms_pkg::DelayW-1:0]  ticks_per_delay_i,
  output i2cms_pkg::out_word_t               res_o
);

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_A    = 5'd1;
  localparam logic [4:0] PH_ST_B    = 5'd2;
  localparam logic [4:0] PH_ST_C    = 5'd3;
  localparam logic [4:0] PH_WR_BIT  = 5'd4;
  localparam logic [4:0] PH_WR_HI   = 5'd5;
  localparam logic [4:0] PH_WR_LO   = 5'd6;
  localparam logic [4:0] PH_WR_AREL = 5'd7;
  localparam logic [4:0] PH_WR_AHI  = 5'd8;
  localparam logic [4:0] PH_WR_ALO  = 5'd9;
  localparam logic [4:0] PH_SP_A    = 5'd10;
  localparam logic [4:0] PH_SP_B    = 5'd11;
  localparam logic [4:0] PH_SP_C    = 5'd12;
  localparam logic [4:0] PH_SP_END  = 5'd13;
  localparam logic [4:0] PH_RD_REL  = 5'd14;
  localparam logic [4:0] PH_RD_HI   = 5'd15;
  localparam logic [4:0] PH_RD_LO   = 5'd16;
  localparam logic [4:0] PH_RD_ACK  = 5'd17;
  localparam logic [4:0] PH_RD_AHI  = 5'd18;
  localparam logic [4:0] PH_RD_ALO  = 5'd19;

  logic [4:0]                    ph_q, ph_d;
  logic [i2cms_pkg::FuncW-1:0]   cmd_q, cmd_d;
  logic [3:0]                    bi_q, bi_d;
  logic [i2cms_pkg::ByteW-1:0]   sh_q, sh_d;
  logic [i2cms_pkg::DelayW-1:0]  cnt_q, cnt_d;
  logic                          ack_q, ack_d;
  logic                          scl_q, scl_d;
  logic                          sda_q, sda_d;
  logic [i2cms_pkg::ByteW-1:0]   rh_q, rh_d;

  logic                          idle;
  logic                          start;
  logic                          run;
  logic [i2cms_pkg::DelayW-1:0]  cnt_dec;
  logic [i2cms_pkg::DelayW-1:0]  tpd_eff;
  logic [4:0]                    e_ph;
  logic [i2cms_pkg::FuncW-1:0]   e_cmd;
  logic [3:0]                    e_bi;
  logic [i2cms_pkg::ByteW-1:0]   e_sh;
  logic [3:0]                    bi_inc;
  logic [4:0]                    n_ph;
  logic [3:0]                    n_bi;
  logic [i2cms_pkg::ByteW-1:0]   n_sh;
  logic                          n_ack;
  logic                          n_scl;
  logic                          n_sda;
  logic [i2cms_pkg::ByteW-1:0]   n_rh;
  logic                          n_done;
  logic                          n_dly;
  logic                          done;

  assign idle    = (ph_q == PH_IDLE);
  assign start   = idle && (word_i.func >= i2cms_pkg::CMD_START)
                        && (word_i.func <= i2cms_pkg::CMD_PROBE);
  assign cnt_dec = cnt_q - 16'd1;
  assign run     = start || (!idle && (cnt_dec == '0));
  assign tpd_eff = (ticks_per_delay_i == '0) ? 16'd1 : ticks_per_delay_i;

  // command entry: pick the first step and load the shifter
  always_comb begin
    e_ph  = ph_q;
    e_cmd = cmd_q;
    e_bi  = bi_q;
    e_sh  = sh_q;
    if (start) begin
      e_cmd = word_i.func;
      e_bi  = 4'd0;
      case (word_i.func)
        i2cms_pkg::CMD_START: e_ph = PH_ST_A;
        i2cms_pkg::CMD_STOP:  e_ph = PH_SP_A;
        i2cms_pkg::CMD_WRITE: begin
          e_sh = word_i.data_byte;
          e_ph = PH_WR_BIT;
        end
        i2cms_pkg::CMD_PROBE: begin
          e_sh = {word_i.data_byte[i2cms_pkg::ByteW-2:0], 1'b0};
          e_ph = PH_ST_A;
        end
        default: e_ph = PH_RD_REL;
      endcase
    end
  end

  assign bi_inc = e_bi + 4'd1;

  // one pass of pin actions, zero-delay steps folded in, until the next delay
  always_comb begin
    n_ph   = e_ph;
    n_bi   = e_bi;
    n_sh   = e_sh;
    n_ack  = ack_q;
    n_scl  = scl_q;
    n_sda  = sda_q;
    n_rh   = rh_q;
    n_done = 1'b0;
    n_dly  = 1'b1;
    case (e_ph)
      PH_ST_A: begin
        n_sda = 1'b1;
        n_scl = 1'b1;
        n_ph  = PH_ST_B;
      end
      PH_ST_B: begin
        n_sda = 1'b0;
        n_ph  = PH_ST_C;
      end
      PH_ST_C: begin
        n_scl = 1'b0;
        if (e_cmd == i2cms_pkg::CMD_PROBE) begin
          n_sda = e_sh[~e_bi[2:0]];
          n_ph  = PH_WR_HI;
        end else begin
          n_done = 1'b1;
        end
      end
      PH_WR_BIT: begin
        n_sda = e_sh[~e_bi[2:0]];
        n_ph  = PH_WR_HI;
      end
      PH_WR_HI: begin
        n_scl = 1'b1;
        n_ph  = PH_WR_LO;
      end
      PH_WR_LO: begin
        n_scl = 1'b0;
        n_bi  = bi_inc;
        if (bi_inc < 4'd8) begin
          n_sda = e_sh[~bi_inc[2:0]];
          n_ph  = PH_WR_HI;
        end else begin
          n_sda = 1'b1;
          n_ph  = PH_WR_AHI;
        end
      end
      PH_WR_AREL: begin
        n_sda = 1'b1;
        n_ph  = PH_WR_AHI;
      end
      PH_WR_AHI: begin
        n_scl = 1'b1;
        n_ack = ~word_i.sda_in;
        n_ph  = PH_WR_ALO;
      end
      PH_WR_ALO: begin
        n_scl = 1'b0;
        if (e_cmd == i2cms_pkg::CMD_PROBE) begin
          n_sda = 1'b0;
          n_ph  = PH_SP_B;
        end else begin
          n_done = 1'b1;
        end
      end
      PH_SP_A: begin
        n_scl = 1'b0;
        n_sda = 1'b0;
        n_ph  = PH_SP_B;
      end
      PH_SP_B: begin
        n_scl = 1'b1;
        n_ph  = PH_SP_C;
      end
      PH_SP_C: begin
        n_sda = 1'b1;
        n_ph  = PH_SP_END;
      end
      PH_RD_REL: begin
        n_sda = 1'b1;
        n_ph  = PH_RD_HI;
      end
      PH_RD_HI: begin
        n_scl = 1'b1;
        n_sh  = {e_sh[i2cms_pkg::ByteW-2:0], word_i.sda_in};
        n_ph  = PH_RD_LO;
      end
      PH_RD_LO: begin
        n_scl = 1'b0;
        n_bi  = bi_inc;
        if (bi_inc < 4'd8) begin
          n_ph = PH_RD_HI;
        end else begin
          n_rh  = e_sh;
          n_sda = (e_cmd == i2cms_pkg::CMD_READACK) ? 1'b0 : 1'b1;
          n_ph  = PH_RD_AHI;
        end
      end
      PH_RD_ACK: begin
        n_sda = (e_cmd == i2cms_pkg::CMD_READACK) ? 1'b0 : 1'b1;
        n_ph  = PH_RD_AHI;
      end
      PH_RD_AHI: begin
        n_scl = 1'b1;
        n_ph  = PH_RD_ALO;
      end
      PH_RD_ALO: begin
        n_scl  = 1'b0;
        n_done = 1'b1;
      end
      default: begin
        // end of stop and any stray code finish the command
        n_done = 1'b1;
      end
    endcase
    if (n_done) begin
      n_ph  = PH_IDLE;
      n_dly = 1'b0;
    end
  end

  assign done = run && n_done;

  always_comb begin
    ph_d  = ph_q;
    cmd_d = cmd_q;
    bi_d  = bi_q;
    sh_d  = sh_q;
    cnt_d = cnt_q;
    ack_d = ack_q;
    scl_d = scl_q;
    sda_d = sda_q;
    rh_d  = rh_q;
    if (fire_i) begin
      if (!idle) begin
        cnt_d = cnt_dec;
      end
      if (run) begin
        ph_d  = n_ph;
        cmd_d = e_cmd;
        bi_d  = n_bi;
        sh_d  = n_sh;
        ack_d = n_ack;
        scl_d = n_scl;
        sda_d = n_sda;
        rh_d  = n_rh;
        if (n_dly) begin
          cnt_d = tpd_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      cmd_q <= i2cms_pkg::CMD_NONE;
      bi_q  <= '0;
      sh_q  <= '0;
      cnt_q <= '0;
      ack_q <= 1'b0;
      scl_q <= 1'b1;
      sda_q <= 1'b1;
      rh_q  <= '0;
    end else begin
      ph_q  <= ph_d;
      cmd_q <= cmd_d;
      bi_q  <= bi_d;
      sh_q  <= sh_d;
      cnt_q <= cnt_d;
      ack_q <= ack_d;
      scl_q <= scl_d;
      sda_q <= sda_d;
      rh_q  <= rh_d;
    end
  end

  always_comb begin
    res_o.scl_out   = scl_d;
    res_o.sda_out   = sda_d;
    res_o.busy_res  = (ph_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.ack_ok    = ack_d;
    res_o.read_byte = rh_d;
  end

endmodule
`default_nettype wire

// ===== design/i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// I2C master bit sequencer, one word per bus tick.
// Input channel (in_valid_i / in_stall_o / in_data_i): each word is one tick
// carrying an optional command (start, stop, write, read with ack or nak,
// probe), the data byte and the sampled SDA level. A command that arrives
// while a sequence is running is dropped.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one word
// per input word, giving SCL/SDA drive levels, busy, a done pulse, the ack
// flag and the last byte read.
// Throughput: one word per clock while the output is not stalled. A word taken
// into the input register has its result loaded into the result register
// when it moves on; the bus step logic in between is a single pass over the
// sequencer state.
// Each bus delay step lasts ticks_per_delay words (zero counts as one). The
// user must write it at APB byte address 0 only while idle; not enforced.
// Stalls: while out_stall_i holds a result, the input register still takes
// one more word, then in_stall_o rises until the result drains.
// Reset: SCL and SDA released, sequencer idle, ticks_per_delay = 1, both
// pipeline registers empty.
module i2c_master_bit_sequencer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire i2cms_pkg::in_word_t               in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output i2cms_pkg::out_word_t                   out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [i2cms_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [i2cms_pkg::ApbDataW-1:0]    pwdata,
  output logic      [i2cms_pkg::ApbDataW-1:0]    prdata,
  output logic                                   pready
);

  logic                          in_vld_q, in_vld_d;
  i2cms_pkg::in_word_t           in_q, in_d;
  logic                          out_vld_q, out_vld_d;
  i2cms_pkg::out_word_t          out_q, out_d;
  i2cms_pkg::out_word_t          res;
  logic [i2cms_pkg::DelayW-1:0]  tpd;
  logic                          consume;
  logic                          accept;

  i2cms_cfg u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_o          (prdata),
    .pready_o          (pready),
    .ticks_per_delay_o (tpd)
  );

  i2cms_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (consume),
    .word_i            (in_q),
    .ticks_per_delay_i (tpd),
    .res_o             (res)
  );

  // the input word moves on when the result register is free or draining
  assign consume    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    in_d     = in_q;
    if (accept) begin
      in_vld_d = 1'b1;
      in_d     = in_data_i;
    end else if (consume) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (consume) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.done_res && out_data_o.busy_res))
    else $error("done and busy reported together");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_consume_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume |=> out_valid_o)
    else $error("processed word did not reach the result register");

  a_held_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("blocked result was dropped");

endmodule
`default_nettype wire

// ===== test/i2c_pin_checker.sv =====
`timescale 1ns / 1ps
module i2c_pin_checker
  import i2cms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_word_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_word_t           out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  localparam logic [ApbAddrW-1:0] TpdAddr = {REG_TICKS_PER_DELAY, 2'b00};

  typedef enum logic [4:0] {
    S_IDLE,
    S_START_REL,
    S_START_SDA,
    S_START_SCL,
    S_WR_BIT,
    S_WR_SCLH,
    S_WR_SCLL,
    S_ACK_REL,
    S_ACK_SCLH,
    S_ACK_SCLL,
    S_STOP_LOW,
    S_STOP_SCLH,
    S_STOP_SDAH,
    S_STOP_END,
    S_RD_REL,
    S_RD_SCLH,
    S_RD_SCLL,
    S_RD_ACK,
    S_RD_ASCLH,
    S_RD_ASCLL
  } seq_phase_e;

  seq_phase_e        phase;
  logic [FuncW-1:0]  cur_cmd;
  logic [3:0]        bit_idx;
  logic [ByteW-1:0]  shreg;
  logic [ByteW-1:0]  rd_hold;
  logic [DelayW-1:0] tpd;
  logic [DelayW-1:0] dly_cnt;
  logic              ack;
  logic              scl_lvl;
  logic              sda_lvl;

  out_word_t         want_pins_q[$];
  out_word_t         want;
  int unsigned       n_words;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic report_err(string msg);
    $display("[%0t] i2c pin check: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val) begin
      report_err($sformatf("word %0d %s: got %0h, expected %0h", n_words, name, got, exp_val));
    end
  endtask

  function automatic void arm_delay(seq_phase_e nxt);
    phase   = nxt;
    dly_cnt = (tpd == '0) ? DelayW'(1) : tpd;
  endfunction

  // walk pin actions until a delay is armed (0) or the command ends (1)
  function automatic logic bus_steps(logic sda);
    logic fin;
    logic go;
    fin = 1'b0;
    go  = 1'b1;
    while (go) begin
      go = 1'b0;
      case (phase)
        S_START_REL: begin
          sda_lvl = 1'b1;
          scl_lvl = 1'b1;
          arm_delay(S_START_SDA);
        end
        S_START_SDA: begin
          sda_lvl = 1'b0;
          arm_delay(S_START_SCL);
        end
        S_START_SCL: begin
          scl_lvl = 1'b0;
          if (cur_cmd == CMD_PROBE) begin
            phase = S_WR_BIT;
            go    = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        S_WR_BIT: begin
          sda_lvl = shreg[3'd7 - bit_idx[2:0]];
          arm_delay(S_WR_SCLH);
        end
        S_WR_SCLH: begin
          scl_lvl = 1'b1;
          arm_delay(S_WR_SCLL);
        end
        S_WR_SCLL: begin
          scl_lvl = 1'b0;
          bit_idx = bit_idx + 4'd1;
          phase   = (bit_idx < 4'd8) ? S_WR_BIT : S_ACK_REL;
          go      = 1'b1;
        end
        S_ACK_REL: begin
          sda_lvl = 1'b1;
          arm_delay(S_ACK_SCLH);
        end
        S_ACK_SCLH: begin
          scl_lvl = 1'b1;
          ack     = ~sda;
          arm_delay(S_ACK_SCLL);
        end
        S_ACK_SCLL: begin
          scl_lvl = 1'b0;
          if (cur_cmd == CMD_PROBE) begin
            phase = S_STOP_LOW;
            go    = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        S_STOP_LOW: begin
          scl_lvl = 1'b0;
          sda_lvl = 1'b0;
          arm_delay(S_STOP_SCLH);
        end
        S_STOP_SCLH: begin
          scl_lvl = 1'b1;
          arm_delay(S_STOP_SDAH);
        end
        S_STOP_SDAH: begin
          sda_lvl = 1'b1;
          arm_delay(S_STOP_END);
        end
        S_RD_REL: begin
          sda_lvl = 1'b1;
          arm_delay(S_RD_SCLH);
        end
        S_RD_SCLH: begin
          scl_lvl = 1'b1;
          shreg   = {shreg[6:0], sda};
          arm_delay(S_RD_SCLL);
        end
        S_RD_SCLL: begin
          scl_lvl = 1'b0;
          bit_idx = bit_idx + 4'd1;
          if (bit_idx < 4'd8) begin
            arm_delay(S_RD_SCLH);
          end else begin
            rd_hold = shreg;
            phase   = S_RD_ACK;
            go      = 1'b1;
          end
        end
        S_RD_ACK: begin
          sda_lvl = (cur_cmd == CMD_READACK) ? 1'b0 : 1'b1;
          arm_delay(S_RD_ASCLH);
        end
        S_RD_ASCLH: begin
          scl_lvl = 1'b1;
          arm_delay(S_RD_ASCLL);
        end
        S_RD_ASCLL: begin
          scl_lvl = 1'b0;
          fin     = 1'b1;
        end
        default: fin = 1'b1;
      endcase
    end
    return fin;
  endfunction

  // one bus tick: returns the pin word the block should give for it
  function automatic out_word_t bus_tick(in_word_t w);
    out_word_t r;
    logic      fin;
    fin = 1'b0;
    if (phase == S_IDLE) begin
      if (w.func >= CMD_START && w.func <= CMD_PROBE) begin
        cur_cmd = w.func;
        bit_idx = '0;
        case (w.func)
          CMD_START: phase = S_START_REL;
          CMD_STOP:  phase = S_STOP_LOW;
          CMD_WRITE: begin
            shreg = w.data_byte;
            phase = S_WR_BIT;
          end
          CMD_PROBE: begin
            // address bit seven falls off here
            shreg = {w.data_byte[6:0], 1'b0};
            phase = S_START_REL;
          end
          default:   phase = S_RD_REL;
        endcase
        fin = bus_steps(w.sda_in);
      end
    end else begin
      dly_cnt = dly_cnt - DelayW'(1);
      if (dly_cnt == '0) fin = bus_steps(w.sda_in);
    end
    if (fin) phase = S_IDLE;
    r.scl_out   = scl_lvl;
    r.sda_out   = sda_lvl;
    r.busy_res  = (phase != S_IDLE);
    r.done_res  = fin;
    r.ack_ok    = ack;
    r.read_byte = rd_hold;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpd     = TicksPerDelayRst;
      phase   = S_IDLE;
      cur_cmd = CMD_NONE;
      bit_idx = '0;
      shreg   = '0;
      rd_hold = '0;
      dly_cnt = '0;
      ack     = 1'b0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      n_words = 0;
      want_pins_q.delete();
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == TpdAddr) begin
        tpd = pwdata_i[DelayW-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (want_pins_q.size() == 0) begin
          report_err($sformatf("word %0d arrived with no word pending", n_words));
        end else begin
          want = want_pins_q.pop_front();
          check_field("scl_out", 8'(out_data_i.scl_out), 8'(want.scl_out));
          check_field("sda_out", 8'(out_data_i.sda_out), 8'(want.sda_out));
          check_field("busy_res", 8'(out_data_i.busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(out_data_i.done_res), 8'(want.done_res));
          check_field("ack_ok", 8'(out_data_i.ack_ok), 8'(want.ack_ok));
          check_field("read_byte", out_data_i.read_byte, want.read_byte);
        end
        n_words++;
      end
      if (in_valid_i && !in_stall_i) want_pins_q.push_back(bus_tick(in_data_i));
      pending_o = want_pins_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import i2cms_pkg::*;

  localparam logic [FuncW-1:0] CMD_UNUSED = 3'd7;
  localparam int unsigned LongDelay  = 40;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned IdlePct    = 22;
  localparam int unsigned CmdPct     = 15;

  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned errors;
  int unsigned pending;
  bit          no_idle;
  int unsigned cur_tpd;
  int unsigned hold_reqs;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  i2c_master_bit_sequencer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  i2c_pin_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_i (out_data_o),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left  = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("no word moved for %0d cycles", QuietLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t mk_word(logic [FuncW-1:0] f, logic [ByteW-1:0] d, logic s);
    in_word_t w;
    w.func      = f;
    w.data_byte = d;
    w.sda_in    = s;
    return w;
  endfunction

  function automatic logic sda_pick(sda_mode_e m);
    case (m)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(1));
    endcase
  endfunction

  function automatic in_word_t rand_word();
    logic [FuncW-1:0] f;
    f = ($urandom_range(99) < CmdPct) ? FuncW'($urandom_range(7)) : CMD_NONE;
    return mk_word(f, ByteW'($urandom), 1'($urandom_range(1)));
  endfunction

  // enough ticks for the longest command (probe) to finish
  function automatic int unsigned settle_ticks();
    return 24 * ((cur_tpd == 0) ? 1 : cur_tpd) + 4;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(in_word_t w);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= $bits(in_word_t)'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_ticks(int unsigned n, sda_mode_e m);
    repeat (n) send_word(mk_word(CMD_NONE, ByteW'($urandom), sda_pick(m)));
  endtask

  task automatic issue(logic [FuncW-1:0] f, logic [ByteW-1:0] d, sda_mode_e m);
    send_word(mk_word(f, d, sda_pick(m)));
    idle_ticks(settle_ticks(), m);
  endtask

  task automatic rand_ticks(int unsigned n);
    repeat (n) send_word(rand_word());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_tpd(int unsigned v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TICKS_PER_DELAY, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_tpd = v;
  endtask

  // done tick of a start at one tick per delay swallows the next command
  task automatic done_tick_case();
    send_word(mk_word(CMD_START, 8'h00, 1'b1));
    send_word(mk_word(CMD_NONE, 8'h00, 1'b0));
    send_word(mk_word(CMD_WRITE, 8'h3c, 1'b0));
    issue(CMD_PROBE, 8'h55, SDA_RAND);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    pready     = 1'b1;
    no_idle    = 1'b0;
    hold_reqs  = 0;
    cur_tpd    = TicksPerDelayRst;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed, at the reset delay
    issue(CMD_START, 8'h00, SDA_RAND);
    issue(CMD_WRITE, 8'h00, SDA_LOW);
    issue(CMD_WRITE, 8'hff, SDA_HIGH);
    issue(CMD_WRITE, 8'ha5, SDA_RAND);
    issue(CMD_READACK, 8'h00, SDA_HIGH);
    issue(CMD_READNAK, 8'hff, SDA_LOW);
    issue(CMD_READACK, 8'h5a, SDA_RAND);
    issue(CMD_PROBE, 8'hff, SDA_LOW);
    issue(CMD_PROBE, 8'h00, SDA_HIGH);
    issue(CMD_STOP, 8'h00, SDA_RAND);
    issue(CMD_UNUSED, 8'hff, SDA_RAND);
    issue(CMD_NONE, 8'hff, SDA_RAND);
    // commands while a start is running
    send_word(mk_word(CMD_START, 8'h00, 1'b0));
    send_word(mk_word(CMD_WRITE, 8'hff, 1'b1));
    send_word(mk_word(CMD_READACK, 8'h00, 1'b0));
    send_word(mk_word(CMD_PROBE, 8'h7f, 1'b1));
    send_word(mk_word(CMD_STOP, 8'h80, 1'b0));
    issue(CMD_READNAK, 8'h01, SDA_RAND);
    done_tick_case();

    // zero delay register acts as one tick
    set_tpd(0);
    done_tick_case();
    rand_ticks(40);

    // long delay: one start spans two full delay steps, no idling anywhere
    set_tpd(LongDelay);
    no_idle = 1'b1;
    send_word(mk_word(CMD_START, 8'h00, 1'b1));
    rand_ticks(2 * LongDelay - 2);
    idle_ticks(6, SDA_RAND);
    no_idle = 1'b0;

    set_tpd(1);
    rand_ticks(40);
    // receiver holds off while words keep coming
    hold_reqs++;
    rand_ticks(80);
    drain();
    rand_ticks(40);

    set_tpd(3);
    rand_ticks(50);

    set_tpd($urandom_range(2, 6));
    rand_ticks(50);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
